@@ design/mcstb_pkg.sv @@
`default_nettype none

package mcstb_pkg;

   // Default geometry of the bank
   localparam int NUM_TIMERS_DEF  = 8;
   localparam int COUNT_WIDTH_DEF = 32;

   // Width of the status and control bits packed in front of period and count
   localparam int REC_FLAG_BITS = 4;

   typedef logic [2:0] func_type;
   typedef logic [1:0] mode_type;

   // Command codes
   localparam func_type FUNC_START  = 3'd0;
   localparam func_type FUNC_STOP   = 3'd1;
   localparam func_type FUNC_PAUSE  = 3'd2;
   localparam func_type FUNC_RESUME = 3'd3;
   localparam func_type FUNC_CHPER  = 3'd4;
   localparam func_type FUNC_TICK   = 3'd5;
   localparam func_type FUNC_RUN    = 3'd6;

   // Per-timer state codes
   localparam mode_type MODE_UNUSED  = 2'd0;
   localparam mode_type MODE_RUNNING = 2'd1;
   localparam mode_type MODE_PAUSED  = 2'd2;
   localparam mode_type MODE_EXPIRED = 2'd3;

endpackage

`default_nettype wire

@@ design/mcstb_timer_ram.sv @@
`default_nettype none

// Timer record store: one write port, one registered read port.
// Entries never written since reset read back as all zeros.
module mcstb_timer_ram
   import mcstb_pkg::*;
#(
   parameter int Depth     = NUM_TIMERS_DEF,
   parameter int DataWidth = REC_FLAG_BITS + 2 * COUNT_WIDTH_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rd_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] rd_addr,
   output logic      [DataWidth-1:0]                  rd_data,
   input  wire logic                                  wr_en,
   input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] wr_addr,
   input  wire logic [DataWidth-1:0]                  wr_data
);

   logic [DataWidth-1:0] timer_ram_ff [Depth];
   logic [Depth-1:0]     entry_live_ff;
   logic [DataWidth-1:0] rd_raw_ff;
   logic                 rd_live_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         timer_ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_ff <= timer_ram_ff[rd_addr];
      end
   end

   // live bits stand in for clearing the array at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_live_ff <= '0;
         rd_live_ff    <= 1'b0;
      end else begin
         if (wr_en) begin
            entry_live_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_live_ff <= entry_live_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_live_ff ? rd_raw_ff : '0;

endmodule

`default_nettype wire

@@ design/multi_channel_soft_timer_bank_unit.sv @@
`default_nettype none

// Bank of NUM_TIMERS one-shot/periodic software-style timers. Each request
// transaction carries a command: start (allocates the lowest unused timer and
// answers with one response giving its id, or a reject when the period is zero
// or the bank is full), stop, pause, resume, change period, tick (counts every
// running timer down, marking it expired at zero) and run (one response per
// expired timer in index order, last set on the final one; periodic timers
// reload, one-shot timers are freed). Stop, pause, resume and change period to
// an id at or above NUM_TIMERS, and the unused command code, do nothing. All
// timer records live in a RAM with one write port and one registered read
// port. Stop writes its entry directly with no read; every other entry access
// goes through a read state (S_RD) and a modify/write state (S_MOD). Pause,
// resume and change period visit one entry, tick and run walk every entry,
// and start walks entries up to the first unused one (all of them when the
// bank is full, none for a zero period). Back pressure on the response side
// adds cycles only when a response must be delivered while the previous one
// is still held. The next request is taken as soon as the current one is
// done, even while its last response still waits in the output register.
// No clearing pass is needed after reset.
module multi_channel_soft_timer_bank_unit
   import mcstb_pkg::*;
#(
   parameter int NUM_TIMERS  = NUM_TIMERS_DEF,
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,

   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [2:0]  req_timer_id,
   input  wire logic [31:0] req_period,
   input  wire logic        req_periodic,
   input  wire logic        req_notify,

   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [2:0]       rsp_result_id,
   output logic             rsp_expired,
   output logic             rsp_notify_out,
   output logic             rsp_last
);

   localparam int IdxWidth  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int RecWidth  = REC_FLAG_BITS + 2 * COUNT_WIDTH;
   localparam logic [IdxWidth-1:0] IdxLast = IdxWidth'(NUM_TIMERS - 1);

   // sequencer states
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_RD     = 3'd1;  // read issued for idx_ff
   localparam logic [2:0] S_MOD    = 3'd2;  // read data back, modify and write
   localparam logic [2:0] S_FLUSH  = 3'd3;  // run done, deliver held result
   localparam logic [2:0] S_REJECT = 3'd4;  // deliver start reject

   logic [2:0]             state_ff, state_in;
   logic [IdxWidth-1:0]    idx_ff, idx_in;

   // latched command
   func_type               func_ff;
   logic [COUNT_WIDTH-1:0] per_ff;
   logic                   periodic_ff;
   logic                   notify_ff;

   // one expired timer held back so that last can be set on the final one
   logic                   pend_valid_ff, pend_valid_in;
   logic [2:0]             pend_id_ff, pend_id_in;
   logic                   pend_notify_ff, pend_notify_in;

   // output register
   logic                   rsp_valid_ff;
   logic                   rsp_status_ff;
   logic [2:0]             rsp_id_ff;
   logic                   rsp_expired_ff;
   logic                   rsp_notify_ff;
   logic                   rsp_last_ff;

   logic                   out_free;
   logic                   out_load;
   logic                   out_status;
   logic [2:0]             out_id;
   logic                   out_expired;
   logic                   out_notify;
   logic                   out_last;

   logic                   req_accept;
   logic                   req_id_ok;
   logic [IdxWidth-1:0]    req_idx;
   logic [COUNT_WIDTH-1:0] req_per;
   logic                   idx_at_end;

   // RAM access
   logic                   rd_en;
   logic                   wr_en;
   logic [IdxWidth-1:0]    wr_addr;
   logic [RecWidth-1:0]    rd_rec;
   logic [RecWidth-1:0]    wr_rec;

   // fields of the record just read
   mode_type               rd_mode;
   logic                   rd_periodic;
   logic                   rd_notify;
   logic [COUNT_WIDTH-1:0] rd_period;
   logic [COUNT_WIDTH-1:0] rd_count;
   logic [COUNT_WIDTH-1:0] cnt_dec;

   // fields of the record to write back
   mode_type               new_mode;
   logic                   new_periodic;
   logic                   new_notify;
   logic [COUNT_WIDTH-1:0] new_period;
   logic [COUNT_WIDTH-1:0] new_count;

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign req_id_ok  = (32'(req_timer_id) < NUM_TIMERS);
   assign req_idx    = IdxWidth'(req_timer_id);
   assign req_per    = COUNT_WIDTH'(req_period);
   assign idx_at_end = (idx_ff == IdxLast);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // record layout: {mode, periodic, notify, period, count}
   assign rd_count    = rd_rec[COUNT_WIDTH-1:0];
   assign rd_period   = rd_rec[2*COUNT_WIDTH-1:COUNT_WIDTH];
   assign rd_notify   = rd_rec[2*COUNT_WIDTH];
   assign rd_periodic = rd_rec[2*COUNT_WIDTH+1];
   assign rd_mode     = rd_rec[2*COUNT_WIDTH+3:2*COUNT_WIDTH+2];
   assign cnt_dec     = rd_count - 1'b1;

   assign wr_rec = {new_mode, new_periodic, new_notify, new_period, new_count};

   mcstb_timer_ram #(
      .Depth     (NUM_TIMERS),
      .DataWidth (RecWidth)
   ) u_timer_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_rec),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_rec)
   );

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      rd_en          = 1'b0;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      new_mode       = rd_mode;
      new_periodic   = rd_periodic;
      new_notify     = rd_notify;
      new_period     = rd_period;
      new_count      = rd_count;
      out_load       = 1'b0;
      out_status     = 1'b0;
      out_id         = 3'(idx_ff);
      out_expired    = 1'b0;
      out_notify     = 1'b0;
      out_last       = 1'b1;
      pend_valid_in  = pend_valid_ff;
      pend_id_in     = pend_id_ff;
      pend_notify_in = pend_notify_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               unique case (req_func)
                  FUNC_START: begin
                     idx_in   = '0;
                     state_in = (req_per == '0) ? S_REJECT : S_RD;
                  end
                  FUNC_STOP: begin
                     // free the timer right away, no read needed
                     if (req_id_ok) begin
                        wr_en        = 1'b1;
                        wr_addr      = req_idx;
                        new_mode     = MODE_UNUSED;
                        new_periodic = 1'b0;
                        new_notify   = 1'b0;
                        new_period   = '0;
                        new_count    = '0;
                     end
                  end
                  FUNC_PAUSE, FUNC_RESUME: begin
                     if (req_id_ok) begin
                        idx_in   = req_idx;
                        state_in = S_RD;
                     end
                  end
                  FUNC_CHPER: begin
                     if (req_id_ok && req_per != '0) begin
                        idx_in   = req_idx;
                        state_in = S_RD;
                     end
                  end
                  FUNC_TICK, FUNC_RUN: begin
                     idx_in   = '0;
                     state_in = S_RD;
                  end
                  default: begin
                     // unused code: nothing to do
                  end
               endcase
            end
         end

         S_RD: begin
            rd_en    = 1'b1;
            state_in = S_MOD;
         end

         S_MOD: begin
            unique case (func_ff)
               FUNC_START: begin
                  if (rd_mode == MODE_UNUSED) begin
                     // wait for the output register before claiming the timer
                     if (out_free) begin
                        wr_en        = 1'b1;
                        new_mode     = MODE_RUNNING;
                        new_periodic = periodic_ff;
                        new_notify   = notify_ff;
                        new_period   = per_ff;
                        new_count    = per_ff;
                        out_load     = 1'b1;
                        state_in     = S_IDLE;
                     end
                  end else if (idx_at_end) begin
                     state_in = S_REJECT;
                  end else begin
                     idx_in   = IdxWidth'(idx_ff + 1'b1);
                     state_in = S_RD;
                  end
               end
               FUNC_PAUSE: begin
                  if (rd_mode == MODE_RUNNING) begin
                     wr_en    = 1'b1;
                     new_mode = MODE_PAUSED;
                  end
                  state_in = S_IDLE;
               end
               FUNC_RESUME: begin
                  if (rd_mode == MODE_PAUSED) begin
                     wr_en    = 1'b1;
                     new_mode = MODE_RUNNING;
                  end
                  state_in = S_IDLE;
               end
               FUNC_CHPER: begin
                  // period always stored, count reloaded only while running
                  wr_en      = 1'b1;
                  new_period = per_ff;
                  if (rd_mode == MODE_RUNNING) begin
                     new_count = per_ff;
                  end
                  state_in = S_IDLE;
               end
               FUNC_TICK: begin
                  if (rd_mode == MODE_RUNNING && rd_count != '0) begin
                     wr_en     = 1'b1;
                     new_count = cnt_dec;
                     if (cnt_dec == '0) begin
                        new_mode = MODE_EXPIRED;
                     end
                  end
                  if (idx_at_end) begin
                     state_in = S_IDLE;
                  end else begin
                     idx_in   = IdxWidth'(idx_ff + 1'b1);
                     state_in = S_RD;
                  end
               end
               FUNC_RUN: begin
                  if (rd_mode != MODE_EXPIRED) begin
                     if (idx_at_end) begin
                        state_in = S_FLUSH;
                     end else begin
                        idx_in   = IdxWidth'(idx_ff + 1'b1);
                        state_in = S_RD;
                     end
                  end else if (!pend_valid_ff || out_free) begin
                     // a newer expiry exists, so the held one is not last
                     if (pend_valid_ff) begin
                        out_load    = 1'b1;
                        out_id      = pend_id_ff;
                        out_expired = 1'b1;
                        out_notify  = pend_notify_ff;
                        out_last    = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_id_in     = 3'(idx_ff);
                     pend_notify_in = rd_notify;
                     wr_en          = 1'b1;
                     if (rd_periodic) begin
                        new_mode  = MODE_RUNNING;
                        new_count = rd_period;
                     end else begin
                        new_mode     = MODE_UNUSED;
                        new_periodic = 1'b0;
                        new_notify   = 1'b0;
                        new_period   = '0;
                        new_count    = '0;
                     end
                     if (idx_at_end) begin
                        state_in = S_FLUSH;
                     end else begin
                        idx_in   = IdxWidth'(idx_ff + 1'b1);
                        state_in = S_RD;
                     end
                  end
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end

         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_id        = pend_id_ff;
               out_expired   = 1'b1;
               out_notify    = pend_notify_ff;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end

         S_REJECT: begin
            if (out_free) begin
               out_load   = 1'b1;
               out_status = 1'b1;
               out_id     = '0;
               state_in   = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         func_ff     <= req_func;
         per_ff      <= req_per;
         periodic_ff <= req_periodic;
         notify_ff   <= req_notify;
      end
      pend_id_ff     <= pend_id_in;
      pend_notify_ff <= pend_notify_in;
      if (out_load) begin
         rsp_status_ff  <= out_status;
         rsp_id_ff      <= out_id;
         rsp_expired_ff <= out_expired;
         rsp_notify_ff  <= out_notify;
         rsp_last_ff    <= out_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_result_id  = rsp_id_ff;
   assign rsp_expired    = rsp_expired_ff;
   assign rsp_notify_out = rsp_notify_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire

@@ verif/timer_bank_monitor.sv @@
`default_nettype none

module timer_bank_monitor
   import mcstb_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_stall,
   input  wire logic [2:0]  req_func,
   input  wire logic [2:0]  req_timer_id,
   input  wire logic [31:0] req_period,
   input  wire logic        req_periodic,
   input  wire logic        req_notify,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_stall,
   input  wire logic        rsp_status,
   input  wire logic [2:0]  rsp_result_id,
   input  wire logic        rsp_expired,
   input  wire logic        rsp_notify_out,
   input  wire logic        rsp_last,
   output int               error_count,
   output int               pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTMR = NUM_TIMERS_DEF;
   localparam int MAX_PRINTS = 40;

   typedef struct packed {
      logic       status;
      logic [2:0] id;
      logic       expired;
      logic       notify;
      logic       last;
   } timer_rsp_type;

   // shadow copy of the bank
   mode_type    tmr_mode     [NTMR];
   logic        tmr_periodic [NTMR];
   logic        tmr_notify   [NTMR];
   logic [31:0] tmr_period   [NTMR];
   logic [31:0] tmr_count    [NTMR];

   timer_rsp_type due_rsp[$];
   int            rsp_seen;

   initial begin
      error_count = 0;
      pending     = 0;
      rsp_seen    = 0;
   end

   function automatic void free_slot(int i);
      tmr_mode[i]     = MODE_UNUSED;
      tmr_periodic[i] = 1'b0;
      tmr_notify[i]   = 1'b0;
      tmr_period[i]   = '0;
      tmr_count[i]    = '0;
   endfunction

   task automatic report_mismatch(string msg);
      if (error_count < MAX_PRINTS)
         $display("[%0t] mismatch on response %0d: %s", $realtime, rsp_seen, msg);
      error_count++;
   endtask

   task automatic compare_field(string name, int got, int want);
      if (got != want)
         report_mismatch($sformatf("%s = %0d, want %0d", name, got, want));
   endtask

   // Work out the responses of one command and advance the shadow bank.
   function automatic void apply_command(func_type f, logic [2:0] id, logic [31:0] per,
                                         logic per_mode, logic ntf);
      timer_rsp_type r;
      int            i;
      int            n_exp;
      int            k;
      bit            found;

      found = 1'b0;
      n_exp = 0;
      k     = 0;
      case (f)
         FUNC_START: begin
            r = '{status: 1'b1, id: 3'd0, expired: 1'b0, notify: 1'b0, last: 1'b1};
            if (per != 0) begin
               for (i = 0; i < NTMR; i++) begin
                  if (!found && tmr_mode[i] == MODE_UNUSED) begin
                     found           = 1'b1;
                     tmr_mode[i]     = MODE_RUNNING;
                     tmr_periodic[i] = per_mode;
                     tmr_notify[i]   = ntf;
                     tmr_period[i]   = per;
                     tmr_count[i]    = per;
                     r.status        = 1'b0;
                     r.id            = 3'(i);
                  end
               end
            end
            due_rsp.push_back(r);
         end
         FUNC_STOP: free_slot(id);
         FUNC_PAUSE: begin
            if (tmr_mode[id] == MODE_RUNNING) tmr_mode[id] = MODE_PAUSED;
         end
         FUNC_RESUME: begin
            if (tmr_mode[id] == MODE_PAUSED) tmr_mode[id] = MODE_RUNNING;
         end
         FUNC_CHPER: begin
            if (per != 0) begin
               tmr_period[id] = per;
               if (tmr_mode[id] == MODE_RUNNING) tmr_count[id] = per;
            end
         end
         FUNC_TICK: begin
            for (i = 0; i < NTMR; i++) begin
               if (tmr_mode[i] == MODE_RUNNING && tmr_count[i] != 0) begin
                  tmr_count[i] = tmr_count[i] - 1;
                  if (tmr_count[i] == 0) tmr_mode[i] = MODE_EXPIRED;
               end
            end
         end
         FUNC_RUN: begin
            for (i = 0; i < NTMR; i++)
               if (tmr_mode[i] == MODE_EXPIRED) n_exp++;
            for (i = 0; i < NTMR; i++) begin
               if (tmr_mode[i] == MODE_EXPIRED) begin
                  r = '{status: 1'b0, id: 3'(i), expired: 1'b1,
                        notify: tmr_notify[i], last: (k == n_exp - 1)};
                  due_rsp.push_back(r);
                  k++;
                  if (tmr_periodic[i]) begin
                     tmr_count[i] = tmr_period[i];
                     tmr_mode[i]  = MODE_RUNNING;
                  end else begin
                     free_slot(i);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic check_response();
      timer_rsp_type want;
      if (due_rsp.size() == 0) begin
         report_mismatch("response with nothing outstanding");
      end else begin
         want = due_rsp.pop_front();
         compare_field("status", rsp_status, want.status);
         compare_field("result_id", rsp_result_id, want.id);
         compare_field("expired", rsp_expired, want.expired);
         compare_field("notify_out", rsp_notify_out, want.notify);
         compare_field("last", rsp_last, want.last);
      end
      rsp_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NTMR; i++) free_slot(i);
         due_rsp.delete();
      end else begin
         // responses first: they always belong to earlier commands
         if (rsp_valid && !rsp_stall) check_response();
         if (req_valid && !req_stall)
            apply_command(func_type'(req_func), req_timer_id, req_period,
                          req_periodic, req_notify);
      end
      pending <= due_rsp.size();
   end

endmodule

`default_nettype wire

@@ verif/multi_channel_soft_timer_bank_unit_tb.sv @@
`default_nettype none

module multi_channel_soft_timer_bank_unit_tb
   import mcstb_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // spare command code, the block must swallow it silently
   localparam func_type FUNC_SPARE = 3'd7;

   // Random commands to issue after the directed opening.
   localparam int RANDOM_ITEMS = 420;
   // Drain time after the last response.
   localparam int DRAIN_CYCLES = 40;
   // Overall cycle limit for the whole test.
   localparam int CYCLE_LIMIT  = 1000000;

   logic        clock;
   logic        reset        = 1'b1;
   logic        req_valid    = 1'b0;
   logic        req_stall;
   logic [2:0]  req_func     = FUNC_TICK;
   logic [2:0]  req_timer_id = 3'd0;
   logic [31:0] req_period   = '0;
   logic        req_periodic = 1'b0;
   logic        req_notify   = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall    = 1'b0;
   logic        rsp_status;
   logic [2:0]  rsp_result_id;
   logic        rsp_expired;
   logic        rsp_notify_out;
   logic        rsp_last;

   int error_count;
   int pending;
   int cycle_count = 0;
   int no_gap_left = 0;

   multi_channel_soft_timer_bank_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_timer_id   (req_timer_id),
      .req_period     (req_period),
      .req_periodic   (req_periodic),
      .req_notify     (req_notify),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_result_id  (rsp_result_id),
      .rsp_expired    (rsp_expired),
      .rsp_notify_out (rsp_notify_out),
      .rsp_last       (rsp_last)
   );

   // Watches both channels, keeps a shadow of the bank and checks every response.
   timer_bank_monitor mon (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_timer_id   (req_timer_id),
      .req_period     (req_period),
      .req_periodic   (req_periodic),
      .req_notify     (req_notify),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_result_id  (rsp_result_id),
      .rsp_expired    (rsp_expired),
      .rsp_notify_out (rsp_notify_out),
      .rsp_last       (rsp_last),
      .error_count    (error_count),
      .pending        (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs or a response never shows up.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycle_count, pending);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Idle time between request transactions: mostly none or short, sometimes
   // long, and now and then a run of back-to-back requests.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_gap_left > 0) begin
         no_gap_left--;
         return 0;
      end
      if (r == 0) begin
         no_gap_left = 40;
         return 0;
      end
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Small periods let timers actually expire; the rest hit the edges or take a random value.
   function automatic logic [31:0] pick_period();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4)  return '0;
      if (r < 8)  return 32'hFFFF_FFFF;
      if (r < 14) return $urandom;
      return $urandom_range(1, 6);
   endfunction

   // Present one request transaction and hold it until the block takes it.
   // Called at a clock edge, returns at an edge. Valid stays up across
   // back-to-back transactions so it never sees two updates in one step.
   task automatic send_cmd(func_type f, logic [2:0] id, logic [31:0] per,
                           logic pm, logic ntf);
      int gap;
      req_valid    <= 1'b1;
      req_func     <= f;
      req_timer_id <= id;
      req_period   <= per;
      req_periodic <= pm;
      req_notify   <= ntf;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Response side back pressure: short and long stall bursts, with quiet
   // stretches where every response goes straight through.
   initial begin
      int hold;
      @(posedge clock);
      forever begin
         if ($urandom_range(0, 19) == 0) begin
            rsp_stall <= 1'b0;
            repeat (150) @(posedge clock);
         end else begin
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                : $urandom_range(1, 3);
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
   end

   initial begin
      int       issued;
      int       sel;
      func_type f;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed opening ----
      send_cmd(FUNC_START,  3'd0, 32'd0,         1'b1, 1'b1); // zero period: rejected
      send_cmd(FUNC_START,  3'd0, 32'd1,         1'b1, 1'b1); // timer 0, periodic
      send_cmd(FUNC_START,  3'd0, 32'd2,         1'b0, 1'b0); // timer 1, one-shot
      send_cmd(FUNC_START,  3'd0, 32'hFFFF_FFFF, 1'b1, 1'b0); // timer 2, max period
      for (int i = 3; i < 8; i++)
         send_cmd(FUNC_START, 3'd0, 32'd3 + 32'(i), i[0], ~i[0]);
      send_cmd(FUNC_START,  3'd7, 32'd5,         1'b0, 1'b1); // bank full: rejected
      send_cmd(FUNC_TICK,   3'd0, 32'd0,         1'b0, 1'b0); // timer 0 expires
      send_cmd(FUNC_PAUSE,  3'd3, 32'd0,         1'b0, 1'b0);
      send_cmd(FUNC_PAUSE,  3'd0, 32'd0,         1'b0, 1'b0); // expired: no effect
      send_cmd(FUNC_RESUME, 3'd4, 32'd0,         1'b0, 1'b0); // not paused: no effect
      send_cmd(FUNC_CHPER,  3'd5, 32'd0,         1'b0, 1'b0); // zero period: no effect
      send_cmd(FUNC_CHPER,  3'd6, 32'd1,         1'b0, 1'b0); // running: reload
      send_cmd(FUNC_CHPER,  3'd3, 32'hFFFF_FFFF, 1'b0, 1'b0); // paused: period only
      send_cmd(FUNC_TICK,   3'd0, 32'd0,         1'b0, 1'b0); // timers 1 and 6 expire
      send_cmd(FUNC_RUN,    3'd0, 32'd0,         1'b0, 1'b0); // three expiries
      send_cmd(FUNC_SPARE,  3'd5, 32'hFFFF_FFFF, 1'b1, 1'b1); // ignored
      send_cmd(FUNC_STOP,   3'd7, 32'd0,         1'b0, 1'b0);
      send_cmd(FUNC_RESUME, 3'd3, 32'd0,         1'b0, 1'b0);
      send_cmd(FUNC_CHPER,  3'd7, 32'd9,         1'b0, 1'b0); // unused timer
      send_cmd(FUNC_RUN,    3'd0, 32'd0,         1'b0, 1'b0); // nothing expired
      send_cmd(FUNC_START,  3'd0, 32'd1,         1'b0, 1'b1); // reuses a freed slot
      send_cmd(FUNC_TICK,   3'd0, 32'd0,         1'b0, 1'b0);
      send_cmd(FUNC_RUN,    3'd0, 32'd0,         1'b0, 1'b0);

      // ---- random commands ----
      // Weighted toward start/tick/run so timers keep cycling through the
      // whole lifecycle; spare codes go in as noise and are not counted.
      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         sel = $urandom_range(0, 99);
         if      (sel < 22) f = FUNC_START;
         else if (sel < 46) f = FUNC_TICK;
         else if (sel < 60) f = FUNC_RUN;
         else if (sel < 72) f = FUNC_STOP;
         else if (sel < 80) f = FUNC_PAUSE;
         else if (sel < 87) f = FUNC_RESUME;
         else if (sel < 96) f = FUNC_CHPER;
         else               f = FUNC_SPARE;
         send_cmd(f, 3'($urandom_range(0, 7)), pick_period(),
                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         if (f != FUNC_SPARE) issued++;
      end
      req_valid <= 1'b0;

      // Let every expected response arrive, then give the block time to show
      // anything extra it might still emit. The count of outstanding responses
      // is a registered value in the monitor.
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
